// File: rtl/hcth_pkg.sv
// Shared types, constants and helpers for the history counter table block.
// Used by the core, hcth_calc and the checker; depends on nothing.
`default_nettype none

package hcth_pkg;

    localparam int LIMIT_W         = 20;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd100000;
    localparam int PIECE_KINDS_DEF = 8;
    localparam int SQUARES_DEF     = 64;
    localparam int PIECE_LSB       = 24;
    localparam int PIECE_FW        = 3;
    localparam int SQUARE_LSB      = 18;
    localparam int SQUARE_FW       = 6;
    localparam int VALUE_W         = 32;
    localparam int BONUS_W         = 16;

    typedef enum logic [1:0] {
        ACT_READ    = 2'd0,
        ACT_REWARD  = 2'd1,
        ACT_PENALTY = 2'd2,
        ACT_CLEAR   = 2'd3
    } hcth_action_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_HALVE,
        S_CLEAR,
        S_DONE
    } hcth_state_t;

    typedef struct packed {
        hcth_action_t action;
        logic         side;
        logic [31:0]  move_word;
        logic [7:0]   depth;
        logic [7:0]   max_depth;
    } hcth_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      halved;
    } hcth_out_t;

    // update result handed from the arithmetic unit to the controller
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      hit;
    } hcth_calc_t;

    // signed divide by two, truncating toward zero
    function automatic logic signed [VALUE_W-1:0] half_toward_zero(
        input logic signed [VALUE_W-1:0] x);
        logic signed [VALUE_W:0] t;
        t = {x[VALUE_W-1], x} + {{VALUE_W{1'b0}}, x[VALUE_W-1]};
        return t[VALUE_W:1];
    endfunction

endpackage

`default_nettype wire

// File: rtl/history_counter_table_with_halving_core.sv
// History counter tables, one per side, with side-wide halving at a threshold.
// Depends on hcth_pkg, hcth_ram and hcth_calc.
//
// Input channel in_valid/in_ready/in_data carries one move per beat: the
// action (read, reward, penalize, clear both tables), the side, the move
// word (piece in bits 26:24, target square in bits 23:18) and the depths.
// Output channel out_valid/out_ready/out_data returns one beat per input
// beat: the touched entry after the action and a flag set when the side
// table was halved. cfg_wr_en/cfg_wr_data set the halving limit at once.
//
// A read, reward or penalty first reads the entry from the table RAM, then
// updates it and writes it back; a new item is taken only once the last one
// is through. A halving adds a sweep of all entries of one side through the
// RAM's read and write ports; a clear sweeps all 2**(piece bits + square
// bits + 1) entries. After reset the block clears both tables the same way
// (1024 entries at default sizes) with in_ready low. The result sits in an
// output register; while the receiver stalls, one more item may be taken and
// processed, and the block then holds its result until the output register
// frees.
`default_nettype none

module history_counter_table_with_halving_core
    import hcth_pkg::*;
#(
    parameter int PIECE_KINDS = PIECE_KINDS_DEF,
    parameter int SQUARES     = SQUARES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hcth_in_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hcth_out_t               out_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [LIMIT_W-1:0] cfg_wr_data
);

    localparam int PBITS = (PIECE_KINDS > 1) ? $clog2(PIECE_KINDS) : 1;
    localparam int SBITS = (SQUARES > 1) ? $clog2(SQUARES) : 1;
    localparam int IDXW  = PBITS + SBITS;
    localparam int AW    = IDXW + 1;
    localparam int DEPTH = 1 << AW;

    hcth_state_t               state_reg, state_next;
    logic [AW-1:0]             cnt_reg, cnt_next;
    hcth_action_t              act_reg, act_next;
    logic                      side_reg, side_next;
    logic [IDXW-1:0]           idx_reg, idx_next;
    logic [BONUS_W-1:0]        bonus_reg, bonus_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      halved_reg, halved_next;
    logic                      out_valid_reg, out_valid_next;
    hcth_out_t                 out_data_reg, out_data_next;
    logic [LIMIT_W-1:0]        limit_reg;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;
    hcth_calc_t                calc;

    logic [PIECE_FW-1:0]       in_piece;
    logic [SQUARE_FW-1:0]      in_square;
    logic                      in_present;
    logic [7:0]                in_dist;
    logic [IDXW-1:0]           in_idx;
    logic [AW-1:0]             cnt_prev;
    logic                      out_free;
    logic                      out_load;
    hcth_out_t                 out_load_data;

    hcth_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    hcth_calc u_calc (
        .old_value (signed'(ram_rdata)),
        .bonus     (bonus_reg),
        .action    (act_reg),
        .limit     (limit_reg),
        .result    (calc)
    );

    always_comb
    begin
        in_piece   = in_data.move_word[PIECE_LSB +: PIECE_FW];
        in_square  = in_data.move_word[SQUARE_LSB +: SQUARE_FW];
        in_present = ({1'b0, in_piece} < (PIECE_FW+1)'(PIECE_KINDS))
                  && ({1'b0, in_square} < (SQUARE_FW+1)'(SQUARES));
        in_dist    = in_data.max_depth - in_data.depth;
        in_idx     = {in_piece[PBITS-1:0], in_square[SBITS-1:0]};
        cnt_prev   = cnt_reg - AW'(1);
        out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        act_next      = act_reg;
        side_next     = side_reg;
        idx_next      = idx_reg;
        bonus_next    = bonus_reg;
        value_next    = value_reg;
        halved_next   = halved_reg;
        in_ready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = {side_reg, idx_reg};
        ram_wdata     = '0;
        ram_raddr     = {side_reg, idx_reg};
        out_load      = 1'b0;
        out_load_data = {value_reg, halved_reg};

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == {AW{1'b1}})
                begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end

            S_IDLE:
            begin
                in_ready  = 1'b1;
                ram_raddr = {in_data.side, in_idx};
                if (in_valid)
                begin
                    act_next    = in_data.action;
                    side_next   = in_data.side;
                    idx_next    = in_idx;
                    bonus_next  = BONUS_W'({8'd0, in_dist} * {8'd0, in_dist});
                    value_next  = '0;
                    halved_next = 1'b0;
                    cnt_next    = '0;
                    if (in_data.action == ACT_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (!in_present)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                if (act_reg == ACT_READ)
                begin
                    value_next = signed'(ram_rdata);
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = calc.value;
                    value_next = calc.value;
                end

                if (act_reg != ACT_READ && calc.hit)
                begin
                    // the sweep re-reads this entry and halves it with the rest
                    value_next  = half_toward_zero(calc.value);
                    halved_next = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_HALVE;
                end
                else if (out_free)
                begin
                    out_load      = 1'b1;
                    out_load_data = {value_next, 1'b0};
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_HALVE:
            begin
                // read one entry per cycle, write back the one read before
                ram_raddr = {side_reg, cnt_reg[IDXW-1:0]};
                ram_waddr = {side_reg, cnt_prev[IDXW-1:0]};
                ram_wdata = half_toward_zero(signed'(ram_rdata));
                ram_we    = (cnt_reg != '0);
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg[IDXW])
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = out_load_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        side_reg     <= side_next;
        idx_reg      <= idx_next;
        bonus_reg    <= bonus_next;
        value_reg    <= value_next;
        halved_reg   <= halved_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/hcth_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module hcth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/hcth_calc.sv
// Saturating reward/penalty update of one counter and the halving threshold test.
// Depends on hcth_pkg.
`default_nettype none

module hcth_calc
    import hcth_pkg::*;
(
    input  wire logic signed [VALUE_W-1:0] old_value,
    input  wire logic [BONUS_W-1:0]        bonus,
    input  wire hcth_action_t              action,
    input  wire logic [LIMIT_W-1:0]        limit,
    output hcth_calc_t                     result
);

    localparam int SUM_W = VALUE_W + 2;

    logic signed [SUM_W-1:0]   old_ext;
    logic signed [SUM_W-1:0]   bonus_ext;
    logic signed [SUM_W-1:0]   sum;
    logic signed [VALUE_W-1:0] sat;
    logic signed [VALUE_W:0]   sat_ext;
    logic signed [VALUE_W:0]   lim_ext;
    logic                      is_penalty;

    always_comb
    begin
        is_penalty = (action == ACT_PENALTY);
        old_ext    = SUM_W'(old_value);
        bonus_ext  = signed'({{(SUM_W-BONUS_W){1'b0}}, bonus});
        sum        = is_penalty ? (old_ext - bonus_ext) : (old_ext + bonus_ext);

        // clamp to the signed 32-bit range
        if (sum > SUM_W'(signed'({1'b0, {(VALUE_W-1){1'b1}}})))
        begin
            sat = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else if (sum < SUM_W'(signed'({1'b1, {(VALUE_W-1){1'b0}}})))
        begin
            sat = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            sat = sum[VALUE_W-1:0];
        end

        sat_ext = (VALUE_W+1)'(sat);
        lim_ext = signed'({{(VALUE_W+1-LIMIT_W){1'b0}}, limit});

        result.value = sat;
        result.hit   = is_penalty ? (sat_ext <= -lim_ext) : (sat_ext >= lim_ext);
    end

endmodule

`default_nettype wire

// File: rtl/hcth_checker.sv
// Port-level checks for the history counter table core, bound to the top level.
// Depends on hcth_pkg and history_counter_table_with_halving_core.
`default_nettype none

module hcth_checker
    import hcth_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire hcth_in_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire hcth_out_t out_data
);

    logic [1:0]   pending_reg;
    hcth_action_t last_act_reg;
    logic         in_beat;
    logic         out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // beats taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            last_act_reg <= ACT_READ;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, in_beat} - {1'b0, out_beat};
            if (in_beat)
            begin
                last_act_reg <= in_data.action;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two beats in flight");

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && in_data.action == ACT_CLEAR |=> !in_ready)
        else $error("input taken during table clear");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pending_reg == 2'd1 && last_act_reg == ACT_CLEAR
        |-> out_data.value == '0 && !out_data.halved)
        else $error("clear returned nonzero result");

    a_read_no_halve: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pending_reg == 2'd1 && last_act_reg == ACT_READ
        |-> !out_data.halved)
        else $error("read reported a halving");

endmodule

bind history_counter_table_with_halving_core hcth_checker u_hcth_checker (.*);

`default_nettype wire
